// ----- src/fafc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fafc_pkg
// Shared types and constants for the fully associative FIFO cache model.
// ----------------------------------------------------------------------------
package fafc_pkg;

  // Field widths fixed by the stream format
  localparam int ADDR_IN_W     = 64;
  localparam int TOTAL_W       = 32;
  localparam int TAG_SHIFT_W   = 6;
  localparam int ACTIVE_WAYS_W = 5;
  localparam int CFG_DATA_W    = 6;
  localparam int CFG_ADDR_W    = 1;
  // hit, evicted, three totals = 98 bits, padded to 13 bytes
  localparam int OUT_TDATA_W   = 104;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_TAG_SHIFT   = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ACTIVE_WAYS = 1'd1;

  // Register reset values
  localparam logic [TAG_SHIFT_W-1:0]   TAG_SHIFT_RST   = 6'd4;
  localparam logic [ACTIVE_WAYS_W-1:0] ACTIVE_WAYS_RST = 5'd16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_UPDATE
  } state_t;

  // Controller -> datapath
  typedef struct packed {
    logic load;    // capture request address, form tag
    logic match;   // register per-way compare results
    logic update;  // commit lookup, load output register
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic out_free;  // output register empty or being drained
  } status_t;

endpackage
`default_nettype wire

// ----- src/fully_assoc_fifo_cache_sim.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fully_assoc_fifo_cache_sim
// Fully associative cache lookup model with FIFO replacement and hit,
// miss and eviction totals.
// ----------------------------------------------------------------------------
// Each request carries one byte address. The tag is the address (low
// ADDR_WIDTH bits) shifted right by tag_shift. It is compared against all
// WAYS resident lines in parallel; a match is a hit, otherwise a miss that
// appends the tag as the youngest line, first dropping the oldest line when
// occupancy has reached active_ways (0 reads as 1, values above WAYS as WAYS).
// Each request yields exactly one result with hit/evicted flags and the
// running totals after this request. A request passes through capture and
// shift, a registered compare across all ways, then the queue update that
// loads the output register. A new request is taken in the cycle after the
// update, even while the previous result still waits in the output register;
// the update stalls only while that register is full and not being drained.
// Configuration writes are only expected while no request is in flight.
// ----------------------------------------------------------------------------
module fully_assoc_fifo_cache_sim #(
  parameter int WAYS        = 16,
  parameter int ADDR_WIDTH  = 64,
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  // request stream
  input  wire logic                                  in_tvalid,
  output logic                                       in_tready,
  input  wire logic [fafc_pkg::ADDR_IN_W-1:0]        in_tdata,   // [63:0] address
  // result stream
  output logic                                       out_tvalid,
  input  wire logic                                  out_tready,
  // [0] hit, [1] evicted, [33:2] hit_total, [65:34] miss_total,
  // [97:66] eviction_total, [103:98] zero
  output logic [fafc_pkg::OUT_TDATA_W-1:0]           out_tdata,
  // configuration write port
  input  wire logic                                  cfg_wr_en,
  input  wire logic [fafc_pkg::CFG_ADDR_W-1:0]       cfg_addr,
  input  wire logic [fafc_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  fafc_pkg::cmd_t    cmd;
  fafc_pkg::status_t status;

  // Configuration registers
  logic [fafc_pkg::TAG_SHIFT_W-1:0]   tag_shift_r;
  logic [fafc_pkg::ACTIVE_WAYS_W-1:0] active_ways_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_shift_r   <= fafc_pkg::TAG_SHIFT_RST;
      active_ways_r <= fafc_pkg::ACTIVE_WAYS_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        fafc_pkg::REG_TAG_SHIFT: begin
          tag_shift_r <= cfg_wdata[fafc_pkg::TAG_SHIFT_W-1:0];
        end
        fafc_pkg::REG_ACTIVE_WAYS: begin
          active_ways_r <= cfg_wdata[fafc_pkg::ACTIVE_WAYS_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  fafc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  fafc_datapath #(
    .WAYS        (WAYS),
    .ADDR_WIDTH  (ADDR_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .status      (status),
    .in_addr     (in_tdata),
    .tag_shift   (tag_shift_r),
    .active_ways (active_ways_r),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  // A hit never evicts
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[1]))
    else $error("hit and evicted both set");

  // One request in flight: no new request right after one is taken
  a_single_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request accepted while another is in flight");

  // Every commit shows up in the output register
  a_commit_publishes: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |=> out_tvalid)
    else $error("committed result missing from output");

  // Commit only when the output register can take the result
  a_commit_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |-> (!out_tvalid || out_tready))
    else $error("result overwritten before being taken");

endmodule
`default_nettype wire

// ----- src/fafc_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fafc_ctrl
// Sequencer: capture request, compare tags, commit and publish result.
// ----------------------------------------------------------------------------
module fafc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire fafc_pkg::status_t status,
  output fafc_pkg::cmd_t         cmd
);

  fafc_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fafc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_tready  = 1'b0;
    unique case (state_r)
      fafc_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = fafc_pkg::ST_MATCH;
        end
      end
      fafc_pkg::ST_MATCH: begin
        cmd.match = 1'b1;
        state_nxt = fafc_pkg::ST_UPDATE;
      end
      fafc_pkg::ST_UPDATE: begin
        // wait for room in the output register
        if (status.out_free) begin
          cmd.update = 1'b1;
          state_nxt  = fafc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = fafc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- src/fafc_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fafc_datapath
// Tag store, parallel compare, FIFO queue pointers, totals, output register.
// ----------------------------------------------------------------------------
module fafc_datapath #(
  parameter int WAYS        = 16,
  parameter int ADDR_WIDTH  = 64,
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire fafc_pkg::cmd_t                         cmd,
  output fafc_pkg::status_t                           status,
  input  wire logic [fafc_pkg::ADDR_IN_W-1:0]         in_addr,
  input  wire logic [fafc_pkg::TAG_SHIFT_W-1:0]       tag_shift,
  input  wire logic [fafc_pkg::ACTIVE_WAYS_W-1:0]     active_ways,
  output logic                                        out_tvalid,
  input  wire logic                                   out_tready,
  output logic [fafc_pkg::OUT_TDATA_W-1:0]            out_tdata
);

  localparam int TW     = fafc_pkg::TOTAL_W;
  localparam int IDX_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int FILL_W = $clog2(WAYS + 1);
  localparam int SUM_W  = FILL_W + 1;
  localparam int AW_W   = fafc_pkg::ACTIVE_WAYS_W;
  localparam int CMP_W  = (FILL_W > AW_W) ? FILL_W : AW_W;
  localparam int PAD_W  = fafc_pkg::OUT_TDATA_W - (2 + 3 * TW);

  // Tag store and queue state
  logic [ADDR_WIDTH-1:0]  tags_r [WAYS];
  logic [WAYS-1:0]        valid_r, valid_nxt;
  logic [IDX_W-1:0]       oldest_r, oldest_nxt;
  logic [FILL_W-1:0]      fill_r, fill_nxt;
  logic [COUNT_WIDTH-1:0] hits_r, hits_nxt;
  logic [COUNT_WIDTH-1:0] misses_r, misses_nxt;
  logic [COUNT_WIDTH-1:0] evicts_r, evicts_nxt;

  // Per-request registers
  logic [ADDR_WIDTH-1:0]  tag_r;
  logic [WAYS-1:0]        match_r;

  // Output register
  logic                   out_valid_r;
  logic                   out_hit_r, out_evicted_r;
  logic [TW-1:0]          out_hits_r, out_misses_r, out_evicts_r;

  logic [CMP_W-1:0]       aw_ext, eff_ways;
  logic                   hit, evict;
  logic [SUM_W-1:0]       slot_sum, slot_mod;
  logic [IDX_W-1:0]       slot;

  // Tag capture: mask to ADDR_WIDTH, then strip offset bits
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tag_r <= in_addr[ADDR_WIDTH-1:0] >> tag_shift;
    end
  end

  // Parallel compare, one comparator per way
  always_ff @(posedge clk) begin
    if (cmd.match) begin
      for (int i = 0; i < WAYS; i++) begin
        match_r[i] <= valid_r[i] && (tags_r[i] == tag_r);
      end
    end
  end

  // Effective way count: 0 acts as 1, above WAYS clamps
  always_comb begin
    aw_ext = CMP_W'(active_ways);
    priority if (aw_ext == '0) begin
      eff_ways = CMP_W'(1);
    end else if (aw_ext > CMP_W'(WAYS)) begin
      eff_ways = CMP_W'(WAYS);
    end else begin
      eff_ways = aw_ext;
    end
  end

  assign hit   = |match_r;
  assign evict = !hit && (CMP_W'(fill_r) >= eff_ways);

  // Insert slot = head + length; eviction moves both so the sum is unchanged
  assign slot_sum = SUM_W'(oldest_r) + SUM_W'(fill_r);
  assign slot_mod = (slot_sum >= SUM_W'(WAYS)) ? slot_sum - SUM_W'(WAYS) : slot_sum;
  assign slot     = IDX_W'(slot_mod);

  always_comb begin
    valid_nxt  = valid_r;
    oldest_nxt = oldest_r;
    fill_nxt   = fill_r;
    hits_nxt   = hits_r;
    misses_nxt = misses_r;
    evicts_nxt = evicts_r;
    if (hit) begin
      hits_nxt = hits_r + 1'b1;
    end else begin
      misses_nxt = misses_r + 1'b1;
      if (evict) begin
        valid_nxt[oldest_r] = 1'b0;
        oldest_nxt = (oldest_r == IDX_W'(WAYS - 1)) ? '0 : oldest_r + 1'b1;
        evicts_nxt = evicts_r + 1'b1;
      end else begin
        fill_nxt = fill_r + 1'b1;
      end
      valid_nxt[slot] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      oldest_r <= '0;
      fill_r   <= '0;
      hits_r   <= '0;
      misses_r <= '0;
      evicts_r <= '0;
    end else if (cmd.update) begin
      valid_r  <= valid_nxt;
      oldest_r <= oldest_nxt;
      fill_r   <= fill_nxt;
      hits_r   <= hits_nxt;
      misses_r <= misses_nxt;
      evicts_r <= evicts_nxt;
    end
  end

  // Tag store write on miss
  always_ff @(posedge clk) begin
    if (cmd.update && !hit) begin
      tags_r[slot] <= tag_r;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.update) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_hit_r     <= hit;
      out_evicted_r <= evict;
      out_hits_r    <= TW'(hits_nxt);
      out_misses_r  <= TW'(misses_nxt);
      out_evicts_r  <= TW'(evicts_nxt);
    end
  end

  assign status.out_free = !out_valid_r || out_tready;
  assign out_tvalid      = out_valid_r;
  assign out_tdata       = {PAD_W'(0), out_evicts_r, out_misses_r, out_hits_r,
                            out_evicted_r, out_hit_r};

endmodule
`default_nettype wire

// ----- tb/fully_assoc_fifo_cache_sim_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fully_assoc_fifo_cache_sim_tb
// Self-checking bench for the fully associative FIFO cache lookup block.
// A short table of directed requests and register writes runs first; a few
// rows carry hand-written results. After it come randomized phases under
// several register settings and pacing modes. Every request goes through a
// local lookup/replacement predictor, and each result is compared field by
// field with the oldest pending prediction.
// ----------------------------------------------------------------------------
module fully_assoc_fifo_cache_sim_tb;

  localparam int LINES           = 16;   // WAYS of the instance
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 204;  // ~1650 requests with the table
  localparam int HOLD_CYCLES     = 300;  // long receiver hold-off
  localparam int RECENT_DEPTH    = 24;   // more than LINES, so old tags come back
  localparam int TAIL_CYCLES     = 4;

  // One prediction: flags plus the running totals after the request
  typedef struct packed {
    logic        hit;
    logic        evicted;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
    logic [31:0] evict_total;
  } access_result_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t                             kind;
    logic [fafc_pkg::CFG_ADDR_W-1:0]       reg_idx;
    logic [fafc_pkg::CFG_DATA_W-1:0]       reg_val;
    logic [fafc_pkg::ADDR_IN_W-1:0]        addr;
    bit                                    typed;   // want holds a hand-written result
    access_result_t                        want;
  } dir_row_t;

  typedef enum int {PACE_STEADY, PACE_TX_IDLE, PACE_RX_STALL, PACE_BOTH} pace_t;

  // --------------------------------------------------------------------------
  // DUT signals; every input is known from time zero
  // --------------------------------------------------------------------------
  logic                             clk        = 1'b0;
  logic                             rst_n      = 1'b0;
  logic                             in_tvalid  = 1'b0;
  logic                             in_tready;
  logic [fafc_pkg::ADDR_IN_W-1:0]   in_tdata   = '0;   // [63:0] address
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  // [0] hit, [1] evicted, [33:2] hit_total, [65:34] miss_total,
  // [97:66] eviction_total, [103:98] zero
  logic [fafc_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                             cfg_wr_en  = 1'b0;
  logic [fafc_pkg::CFG_ADDR_W-1:0]  cfg_addr   = '0;
  logic [fafc_pkg::CFG_DATA_W-1:0]  cfg_wdata  = '0;

  fully_assoc_fifo_cache_sim dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Cache predictor: circular queue of tags, head_slot is the oldest line
  // --------------------------------------------------------------------------
  logic [63:0]            line_tag   [LINES];
  bit                     line_live  [LINES] = '{default: 1'b0};
  logic [3:0]             head_slot  = '0;
  logic [4:0]             fill_count = '0;
  logic [31:0]            hit_cnt    = '0;
  logic [31:0]            miss_cnt   = '0;
  logic [31:0]            evict_cnt  = '0;
  logic [fafc_pkg::TAG_SHIFT_W-1:0]   shift_cfg = fafc_pkg::TAG_SHIFT_RST;
  logic [fafc_pkg::ACTIVE_WAYS_W-1:0] ways_cfg  = fafc_pkg::ACTIVE_WAYS_RST;

  access_result_t pending_results[$];   // predictions not yet matched
  logic [63:0]    recent_addrs[$];      // pool to draw re-used tags from
  dir_row_t       plan[$];              // directed table

  int mismatches   = 0;
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int hold_req     = 0;   // bumped by the stimulus to start a hold-off
  int hold_seen    = 0;
  int hold_left    = 0;

  function automatic access_result_t lookup_and_fill(input logic [63:0] addr);
    logic [63:0]    tag_val;
    int             eff_ways;
    logic [3:0]     slot;
    access_result_t r;
    tag_val = addr >> shift_cfg;
    r = '0;
    for (int i = 0; i < LINES; i++)
      if (line_live[i] && line_tag[i] == tag_val) r.hit = 1'b1;
    if (r.hit) begin
      hit_cnt++;
    end else begin
      miss_cnt++;
      // 0 reads as one way, anything above the array size as all ways
      eff_ways = (ways_cfg == 0) ? 1 : (ways_cfg > LINES) ? LINES : int'(ways_cfg);
      // also covers a way count lowered below the current fill: one drop only
      if (fill_count >= eff_ways) begin
        line_live[head_slot] = 1'b0;
        head_slot++;
        fill_count--;
        r.evicted = 1'b1;
        evict_cnt++;
      end
      slot = head_slot + fill_count[3:0];
      line_tag[slot]  = tag_val;
      line_live[slot] = 1'b1;
      fill_count++;
    end
    r.hit_total   = hit_cnt;
    r.miss_total  = miss_cnt;
    r.evict_total = evict_cnt;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Directed table helpers
  // --------------------------------------------------------------------------
  function automatic dir_row_t row_req(input logic [63:0] a);
    dir_row_t row;
    row = '{ROW_REQ, '0, '0, a, 1'b0, '0};
    return row;
  endfunction

  function automatic dir_row_t row_req_exp(input logic [63:0] a, input logic h,
                                           input logic ev, input int hits,
                                           input int misses, input int evicts);
    dir_row_t row;
    row = '{ROW_REQ, '0, '0, a, 1'b1, '{h, ev, hits, misses, evicts}};
    return row;
  endfunction

  function automatic dir_row_t row_cfg(input logic [fafc_pkg::CFG_ADDR_W-1:0] idx,
                                       input logic [fafc_pkg::CFG_DATA_W-1:0] val);
    dir_row_t row;
    row = '{ROW_CFG, idx, val, '0, 1'b0, '0};
    return row;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Mostly re-used tags with fresh offset bits, some from a narrow window of
  // tags, the rest fully random addresses.
  function automatic logic [63:0] pick_address();
    logic [63:0] a;
    logic [63:0] low_mask;
    int          r;
    r = $urandom_range(99);
    low_mask = (64'd1 << shift_cfg) - 64'd1;
    if (r < 55 && recent_addrs.size() > 0)
      a = (recent_addrs[$urandom_range(recent_addrs.size() - 1)] & ~low_mask) |
          (rand64() & low_mask);
    else if (r < 80)
      a = (64'($urandom_range(0, 24)) << shift_cfg) | (rand64() & low_mask);
    else
      a = rand64();
    recent_addrs.push_back(a);
    if (recent_addrs.size() > RECENT_DEPTH) void'(recent_addrs.pop_front());
    return a;
  endfunction

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  task automatic send_access(input logic [63:0] addr, input bit typed,
                             input access_result_t typed_res);
    access_result_t r;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= addr;
    do @(posedge clk); while (!in_tready);
    // predictor always advances; hand-written rows override its answer
    r = lookup_and_fill(addr);
    pending_results.push_back(typed ? typed_res : r);
  endtask

  // Park the request side until every result is back and the pipe is empty
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [fafc_pkg::CFG_ADDR_W-1:0] idx,
                           input logic [fafc_pkg::CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    if (idx == fafc_pkg::REG_TAG_SHIFT) shift_cfg = val[fafc_pkg::TAG_SHIFT_W-1:0];
    else                                ways_cfg  = val[fafc_pkg::ACTIVE_WAYS_W-1:0];
  endtask

  // --------------------------------------------------------------------------
  // Result side: random back-pressure plus an occasional long hold-off
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_pacing
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  function automatic void compare_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
    if (got !== want) begin
      if (mismatches < 10)
        $display("[%0t] %s mismatch: expected %0h, got %0h", $realtime, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    access_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        if (mismatches < 10)
          $display("[%0t] result with no request pending: %h", $realtime, out_tdata);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        compare_field("hit",            want.hit,         out_tdata[0]);
        compare_field("evicted",        want.evicted,     out_tdata[1]);
        compare_field("hit_total",      want.hit_total,   out_tdata[33:2]);
        compare_field("miss_total",     want.miss_total,  out_tdata[65:34]);
        compare_field("eviction_total", want.evict_total, out_tdata[97:66]);
        compare_field("padding",        64'd0,
                      out_tdata[fafc_pkg::OUT_TDATA_W-1:98]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [fafc_pkg::CFG_DATA_W-1:0] sh;
    logic [fafc_pkg::CFG_DATA_W-1:0] wy;
    pace_t                           pace;

    // Reset state: shift 4, 16 ways, empty cache, zero totals
    plan.push_back(row_req_exp(64'h0, 1'b0, 1'b0, 0, 1, 0));
    plan.push_back(row_req_exp(64'hF, 1'b1, 1'b0, 1, 1, 0));          // same line
    plan.push_back(row_req_exp('1, 1'b0, 1'b0, 1, 2, 0));             // all ones
    plan.push_back(row_req_exp(64'hFFFF_FFFF_FFFF_FFF0, 1'b1, 1'b0, 2, 2, 0));
    // no shift: tag is the whole address; stored tag 0 still matches
    plan.push_back(row_cfg(fafc_pkg::REG_TAG_SHIFT, 6'd0));
    plan.push_back(row_req_exp(64'h0, 1'b1, 1'b0, 3, 2, 0));
    plan.push_back(row_req('1));
    // widest shift: only the top address bit survives
    plan.push_back(row_cfg(fafc_pkg::REG_TAG_SHIFT, 6'd63));
    plan.push_back(row_req(64'h8000_0000_0000_0000));
    plan.push_back(row_req(64'h7FFF_FFFF_FFFF_FFFF));
    // zero ways acts as one, and drops below the current fill
    plan.push_back(row_cfg(fafc_pkg::REG_ACTIVE_WAYS, 6'd0));
    plan.push_back(row_cfg(fafc_pkg::REG_TAG_SHIFT, 6'd4));
    plan.push_back(row_req(64'h100));
    plan.push_back(row_req(64'h104));
    plan.push_back(row_req(64'h200));
    // way count above the array size acts as all ways
    plan.push_back(row_cfg(fafc_pkg::REG_ACTIVE_WAYS, 6'd31));
    plan.push_back(row_req(64'h300));
    plan.push_back(row_req(64'h400));
    plan.push_back(row_cfg(fafc_pkg::REG_ACTIVE_WAYS, 6'd1));
    plan.push_back(row_req(64'h500));
    plan.push_back(row_req(64'h508));
    plan.push_back(row_cfg(fafc_pkg::REG_ACTIVE_WAYS, 6'd16));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        wait_drained();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        send_access(plan[i].addr, plan[i].typed, plan[i].want);
      end
    end
    wait_drained();

    for (int phase = 0; phase < PHASES; phase++) begin
      // register settings per phase, extremes included; random values
      // on the ways register also toggle the unused top data bit
      case (phase)
        0:       begin sh = 6'd4;  wy = 6'd16; end
        1:       begin sh = 6'd0;  wy = 6'd1;  end
        2:       begin sh = 6'd6;  wy = 6'd0;  end
        3:       begin sh = 6'd63; wy = 6'd31; end
        5:       begin sh = 6'd12; wy = 6'd8;  end
        7:       begin sh = 6'd1;  wy = 6'd34; end   // reads as 2 ways
        default: begin
          sh = 6'($urandom_range(0, 63));
          wy = 6'($urandom_range(0, 63));
        end
      endcase
      write_reg(fafc_pkg::REG_TAG_SHIFT, sh);
      write_reg(fafc_pkg::REG_ACTIVE_WAYS, wy);

      pace = pace_t'(phase % 4);
      case (pace)
        PACE_STEADY:   begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        PACE_TX_IDLE:  begin tx_idle_pct = 76; rx_stall_pct = 0;  end
        PACE_RX_STALL: begin tx_idle_pct = 0;  rx_stall_pct = 76; end
        default:       begin tx_idle_pct = 8;  rx_stall_pct = 8;  end
      endcase

      // receiver holds off while requests keep coming: output fills, input stalls
      if (phase == 2) hold_req++;

      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        // sender pauses mid-phase until every result is back
        if (phase == 5 && k == ITEMS_PER_PHASE / 2) wait_drained();
        send_access(pick_address(), 1'b0, '0);
      end
      wait_drained();
    end

    if (pending_results.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Timeout set well beyond the slowest correct run
  initial begin : watchdog
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- fully_assoc_fifo_cache_sim.f -----
src/fafc_pkg.sv
src/fafc_ctrl.sv
src/fafc_datapath.sv
src/fully_assoc_fifo_cache_sim.sv
tb/fully_assoc_fifo_cache_sim_tb.sv
